### design/hns_pkg.sv
`default_nettype none

package hns_pkg;

   localparam int COORD_W = 8;
   localparam int DIM_W   = 9;
   localparam int REACH_W = 2;
   localparam int ROW_W   = 10;
   localparam int COL_W   = 3;
   localparam int CSR_W   = 2;

   localparam int MAX_RANGE = 3;
   localparam int MAP_MAX   = 256;

   localparam logic [CSR_W-1:0] CSR_MAP_WIDTH  = 2'd0;
   localparam logic [CSR_W-1:0] CSR_MAP_HEIGHT = 2'd1;
   localparam logic [CSR_W-1:0] CSR_HEX_MODE   = 2'd2;

   typedef struct packed {
      logic [COORD_W-1:0] center_x;
      logic [COORD_W-1:0] center_y;
      logic [REACH_W-1:0] reach;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] sector_x;
      logic [COORD_W-1:0] sector_y;
      logic               last;
   } rsp_type;

   // zero reads as one, anything above the largest map saturates
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] res;
      res = v;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (v > DIM_W'(MAP_MAX)) begin
         res = DIM_W'(MAP_MAX);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

### design/hex_neighborhood_scanner_top.sv
`default_nettype none

// sequence: accept in ST_IDLE, the remainder wait (ST_MOD), a walk back to the first
//   column (ST_BACK), then per column a setup state (ST_COL) and a walk over its candidate
//   rows (ST_ROW), then a flush state (ST_FLUSH)
// a new center is taken only in ST_IDLE, so one scan ends before the next one begins
// the remainder unit and the row walk take most of a scan; output stalls stretch it
// reset: sequencer idle, no beat pending, map 256 by 256 in hex mode

module hex_neighborhood_scanner_top import hns_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   // input beats
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire req_type          req_data,
   // result beats
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_type               rsp_data,
   // register writes
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CSR_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MOD,
      ST_BACK,
      ST_COL,
      ST_ROW,
      ST_FLUSH
   } state_type;

   // configuration registers
   logic [DIM_W-1:0] map_width_ff;
   logic [DIM_W-1:0] map_height_ff;
   logic             hex_mode_ff;

   // sequencer state
   state_type          state_ff, state_in;
   logic [COORD_W-1:0] cx_ff, cx_in;
   logic [COORD_W-1:0] cy_ff, cy_in;
   logic [REACH_W-1:0] r_ff, r_in;
   logic [REACH_W-1:0] back_ff, back_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic signed [ROW_W-1:0] row_ff, row_in;
   logic signed [ROW_W-1:0] row_end_ff, row_end_in;

   // one sector held back so the final one can carry last
   logic               pend_valid_ff, pend_valid_in;
   logic [COORD_W-1:0] pend_x_ff, pend_x_in;
   logic [COORD_W-1:0] pend_y_ff, pend_y_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // remainder unit hookup
   logic               rem_start;
   logic               rem_done;
   logic [COORD_W-1:0] rem_value;

   // datapath helpers
   logic [DIM_W-1:0]   w_clamp;
   logic [DIM_W-1:0]   h_clamp;
   logic               out_free;
   logic [COL_W-1:0]   two_r;
   logic [COL_W-1:0]   dx_abs;
   logic [COL_W-1:0]   span;
   logic [COL_W-1:0]   half;
   logic signed [ROW_W-1:0] cy_s;
   logic signed [ROW_W-1:0] ystart;
   logic signed [ROW_W-1:0] yend;
   logic               row_on_map;
   logic [DIM_W-1:0]   x_plus;
   logic [COORD_W-1:0] x_next;
   logic [COORD_W-1:0] x_prev;
   logic               stall;

   // the remainder starts on the accept edge, so it takes the center straight off the beat
   hns_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (req_data.center_x),
      .divisor   (w_clamp),
      .done      (rem_done),
      .remainder (rem_value)
   );

   // configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= DIM_W'(256);
         map_height_ff <= DIM_W'(256);
         hex_mode_ff   <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MAP_WIDTH:  map_width_ff  <= csr_data;
            CSR_MAP_HEIGHT: map_height_ff <= csr_data;
            CSR_HEX_MODE:   hex_mode_ff   <= csr_data[0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      w_clamp  = clamp_dim(map_width_ff);
      h_clamp  = clamp_dim(map_height_ff);
      out_free = !rsp_valid_ff || rsp_ready;

      // column geometry: col runs 0..2r, dx = col - r
      two_r  = {1'b0, r_ff} << 1;
      dx_abs = (col_ff >= COL_W'(r_ff)) ? (col_ff - COL_W'(r_ff)) : (COL_W'(r_ff) - col_ff);
      span   = two_r - dx_abs;
      // even center column pulls the span up by one extra half row
      half  = COL_W'(({1'b0, span} + {{COL_W{1'b0}}, ~cx_ff[0]}) >> 1);
      cy_s  = $signed(ROW_W'(cy_ff));
      if (hex_mode_ff) begin
         ystart = cy_s - $signed(ROW_W'(half));
         yend   = ystart + $signed(ROW_W'(span));
      end else begin
         ystart = cy_s - $signed(ROW_W'(r_ff));
         yend   = cy_s + $signed(ROW_W'(r_ff));
      end

      row_on_map = !row_ff[ROW_W-1] && ($unsigned(row_ff) < ROW_W'(h_clamp));

      // column stepping with wrap around the map width
      x_plus = DIM_W'(x_ff) + DIM_W'(1);
      x_next = (x_plus == w_clamp) ? '0 : x_plus[COORD_W-1:0];
      x_prev = (x_ff == '0) ? COORD_W'(w_clamp - DIM_W'(1)) : (x_ff - 1'b1);

      // a new on-map sector must push the held one, which needs room at the output
      stall = row_on_map && pend_valid_ff && !out_free;

      state_in      = state_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      r_in          = r_ff;
      back_in       = back_ff;
      col_in        = col_ff;
      x_in          = x_ff;
      row_in        = row_ff;
      row_end_in    = row_end_ff;
      pend_valid_in = pend_valid_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rem_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cx_in         = req_data.center_x;
               cy_in         = req_data.center_y;
               r_in          = (req_data.reach > REACH_W'(MAX_RANGE)) ?
                               REACH_W'(MAX_RANGE) : req_data.reach;
               col_in        = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_MOD;
            end
         end
         ST_MOD: begin
            // remainder was kicked on the accept edge, wait for it
            if (rem_done) begin
               x_in     = rem_value;
               back_in  = r_ff;
               state_in = ST_BACK;
            end
         end
         ST_BACK: begin
            // walk from the center column back to the leftmost one
            if (back_ff == '0) begin
               state_in = ST_COL;
            end else begin
               x_in    = x_prev;
               back_in = back_ff - 1'b1;
            end
         end
         ST_COL: begin
            row_in     = ystart;
            row_end_in = yend;
            state_in   = ST_ROW;
         end
         ST_ROW: begin
            if (!stall) begin
               if (row_on_map) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in         = 1'b1;
                     rsp_data_in.sector_x = pend_x_ff;
                     rsp_data_in.sector_y = pend_y_ff;
                     rsp_data_in.last     = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_x_in     = x_ff;
                  pend_y_in     = row_ff[COORD_W-1:0];
               end
               if (row_ff == row_end_ff) begin
                  if (col_ff == two_r) begin
                     state_in = ST_FLUSH;
                  end else begin
                     col_in   = col_ff + 1'b1;
                     x_in     = x_next;
                     state_in = ST_COL;
                  end
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            // held sector goes out flagged last; an empty neighborhood emits nothing
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.sector_x = pend_x_ff;
               rsp_data_in.sector_y = pend_y_ff;
               rsp_data_in.last     = 1'b1;
               pend_valid_in        = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (state_ff == ST_IDLE && req_valid) begin
         rem_start = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         col_ff        <= '0;
         back_ff       <= '0;
         r_ff          <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         col_ff        <= col_in;
         back_ff       <= back_in;
         r_ff          <= r_in;
      end
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      x_ff        <= x_in;
      row_ff      <= row_in;
      row_end_ff  <= row_end_in;
      pend_x_ff   <= pend_x_in;
      pend_y_ff   <= pend_y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // nothing may be held back once the sequencer is idle again
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held sector left behind at idle");

   // the row walk never passes the end of its column
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW) |-> (row_ff <= row_end_ff))
      else $error("row cursor beyond column end");

   // the wrapped column stays on the map
   a_x_on_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROW) |-> (DIM_W'(x_ff) < w_clamp))
      else $error("column outside map width");

   // column counter stays within the neighborhood
   a_col_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COL || state_ff == ST_ROW) |-> (col_ff <= two_r))
      else $error("column counter out of range");

   // a push to the output only happens when the output register has room
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_data_ff))
      else $error("pending result overwritten");

endmodule

`default_nettype wire

### design/hns_rem.sv
`default_nettype none

// restoring remainder, one dividend bit per cycle
module hns_rem import hns_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [COORD_W-1:0] dividend,
   input  wire logic [DIM_W-1:0]   divisor,
   output logic                    done,
   output logic [COORD_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(COORD_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COORD_W-1:0] dvd_ff, dvd_in;
   logic [DIM_W-1:0]   rem_ff, rem_in;
   logic [DIM_W-1:0]   shifted;

   always_comb begin
      shifted = {rem_ff[COORD_W-1:0], dvd_ff[COORD_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = (shifted >= divisor) ? (shifted - divisor) : shifted;
         dvd_in = {dvd_ff[COORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(COORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[COORD_W-1:0];

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb import hns_pkg::*; ();

   // unmapped register index, writes to it must be dropped
   localparam logic [CSR_W-1:0] CSR_SPARE = 2'd3;
   // a center that yields no sector can keep the scanner busy this long
   localparam int DRAIN_CYCLES    = 100;
   localparam int IDLE_LIMIT      = 5000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 60;

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_index = CSR_MAP_WIDTH;
   logic [DIM_W-1:0]   csr_data  = '0;

   hex_neighborhood_scanner_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // mirror of the map registers, reset values of the block
   logic [DIM_W-1:0] map_width_q  = DIM_W'(MAP_MAX);
   logic [DIM_W-1:0] map_height_q = DIM_W'(MAP_MAX);
   logic             hex_mode_q   = 1'b1;

   req_type pending_centers[$];    // centers waiting for the driver
   rsp_type expected_sectors[$];   // sectors predicted, not yet seen
   rsp_type want_sector;

   int send_pct = 0;               // chance per cycle that the sender idles
   int recv_pct = 0;               // chance per cycle that the receiver stalls
   int centers_queued   = 0;
   int centers_accepted = 0;
   int empty_centers    = 0;
   int sectors_checked  = 0;
   int reg_writes       = 0;
   int failures         = 0;
   int idle_cycles      = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // zero reads as one, oversize saturates to the largest map
   function automatic int eff_dim(input logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (int'(v) > MAP_MAX) return MAP_MAX;
      return int'(v);
   endfunction

   // walks the neighborhood column by column, pushing every on-map sector
   function automatic void enumerate_neighborhood(input req_type c);
      int      w;
      int      h;
      int      cx;
      int      cy;
      int      r;
      int      dx;
      int      dx_abs;
      int      span;
      int      ystart;
      int      yend;
      int      xreal;
      int      y;
      bit      have_prev;
      rsp_type prev;
      w         = eff_dim(map_width_q);
      h         = eff_dim(map_height_q);
      cx        = int'(c.center_x);
      cy        = int'(c.center_y);
      r         = int'(c.reach);
      have_prev = 1'b0;
      prev      = '0;
      if (r > MAX_RANGE) r = MAX_RANGE;
      for (dx = -r; dx <= r; dx++) begin
         dx_abs = (dx < 0) ? -dx : dx;
         if (hex_mode_q) begin
            // even center columns shift the span up by half a row
            span   = 2 * r - dx_abs;
            ystart = cy - (span + ((cx + 1) % 2)) / 2;
            yend   = ystart + span;
         end else begin
            ystart = cy - r;
            yend   = cy + r;
         end
         // true modulo, columns may repeat on narrow maps
         xreal = (cx + dx) % w;
         if (xreal < 0) xreal += w;
         for (y = ystart; y <= yend; y++) begin
            if (y >= 0 && y < h) begin
               if (have_prev) expected_sectors.push_back(prev);
               prev.sector_x = COORD_W'(xreal);
               prev.sector_y = COORD_W'(y);
               prev.last     = 1'b0;
               have_prev     = 1'b1;
            end
         end
      end
      if (have_prev) begin
         prev.last = 1'b1;
         expected_sectors.push_back(prev);
      end else begin
         empty_centers++;
      end
   endfunction

   task automatic queue_center(input int cx, input int cy, input int r);
      req_type c;
      c.center_x = COORD_W'(cx);
      c.center_y = COORD_W'(cy);
      c.reach    = REACH_W'(r);
      pending_centers.push_back(c);
      centers_queued++;
   endtask

   // one register write beat, mirror updated once the beat is taken
   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [DIM_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      reg_writes++;
      case (idx)
         CSR_MAP_WIDTH:  map_width_q  = val;
         CSR_MAP_HEIGHT: map_height_q = val;
         CSR_HEX_MODE:   hex_mode_q   = val[0];
         default: ;
      endcase
   endtask

   // every center taken, every sector seen, then room for a silent scan
   task automatic wait_drained();
      do @(posedge clock);
      while (centers_accepted != centers_queued || expected_sectors.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver: a new beat goes out only once the slot is free
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            enumerate_neighborhood(req_data);
            centers_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pending_centers.size() != 0 && $urandom_range(99) >= send_pct) begin
               req_data  <= pending_centers.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // sector monitor and receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sectors.size() == 0) begin
               $error("unexpected sector beat x=%0d y=%0d last=%0b",
                      rsp_data.sector_x, rsp_data.sector_y, rsp_data.last);
               failures++;
            end else begin
               want_sector = expected_sectors.pop_front();
               if (rsp_data.sector_x !== want_sector.sector_x) begin
                  $error("sector_x expected %0d got %0d",
                         want_sector.sector_x, rsp_data.sector_x);
                  failures++;
               end
               if (rsp_data.sector_y !== want_sector.sector_y) begin
                  $error("sector_y expected %0d got %0d",
                         want_sector.sector_y, rsp_data.sector_y);
                  failures++;
               end
               if (rsp_data.last !== want_sector.last) begin
                  $error("last expected %0b got %0b", want_sector.last, rsp_data.last);
                  failures++;
               end
            end
            sectors_checked++;
         end
         rsp_ready <= ($urandom_range(99) >= recv_pct);
      end
   end

   // watchdog: too long without any beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("hex_neighborhood_scanner_top regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int  p;
      int  i;
      int  k;
      int  t;
      int  w_eff;
      int  h_eff;
      int  cx;
      int  cy;
      logic [DIM_W-1:0] dim;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: reset map, corners, both column parities, reach zero
      queue_center(0, 0, 3);
      queue_center(255, 255, 3);
      queue_center(1, 128, 3);
      queue_center(2, 128, 3);
      queue_center(100, 100, 0);
      queue_center(170, 85, 2);
      wait_drained();

      // square neighborhood, full 49 sectors and a corner
      write_reg(CSR_HEX_MODE, DIM_W'(0));
      queue_center(128, 128, 3);
      queue_center(255, 0, 1);
      wait_drained();

      // zero dimensions read as one: repeated column, then nothing on the map
      write_reg(CSR_MAP_WIDTH, DIM_W'(0));
      write_reg(CSR_MAP_HEIGHT, DIM_W'(0));
      queue_center(0, 0, 3);
      queue_center(255, 5, 2);
      wait_drained();

      // oversize dimensions saturate, spare index must not touch anything
      write_reg(CSR_MAP_WIDTH, DIM_W'(511));
      write_reg(CSR_MAP_HEIGHT, DIM_W'(300));
      write_reg(CSR_HEX_MODE, DIM_W'(1));
      write_reg(CSR_SPARE, DIM_W'(9'h1ff));
      queue_center(255, 255, 3);
      queue_center(0, 254, 1);
      wait_drained();

      // reach beyond the map width and center outside it
      write_reg(CSR_MAP_WIDTH, DIM_W'(2));
      write_reg(CSR_MAP_HEIGHT, DIM_W'(3));
      queue_center(1, 1, 3);
      queue_center(170, 2, 3);
      wait_drained();

      // single row map in square mode
      write_reg(CSR_MAP_WIDTH, DIM_W'(256));
      write_reg(CSR_MAP_HEIGHT, DIM_W'(1));
      write_reg(CSR_HEX_MODE, DIM_W'(0));
      queue_center(85, 0, 3);
      queue_center(7, 3, 3);
      wait_drained();

      // random phases, each with its own map and idling pattern
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0: begin send_pct = 0;  recv_pct = 0;  end
            1: begin send_pct = 77; recv_pct = 0;  end
            2: begin send_pct = 0;  recv_pct = 77; end
            default: begin send_pct = 26; recv_pct = 26; end
         endcase
         for (i = 0; i < 2; i++) begin
            k = $urandom_range(19);
            if (p < 2)       dim = DIM_W'(MAP_MAX);
            else if (k < 3)  dim = DIM_W'(1);
            else if (k < 5)  dim = DIM_W'(MAP_MAX);
            else if (k == 5) dim = DIM_W'(0);
            else if (k == 6) dim = DIM_W'($urandom_range(511, 257));
            else if (k < 10) dim = DIM_W'($urandom_range(8, 2));
            else             dim = DIM_W'($urandom_range(256, 1));
            write_reg((i == 0) ? CSR_MAP_WIDTH : CSR_MAP_HEIGHT, dim);
         end
         if (p < 2) write_reg(CSR_HEX_MODE, DIM_W'(p == 0));
         else       write_reg(CSR_HEX_MODE, DIM_W'($urandom_range(1)));
         w_eff = eff_dim(map_width_q);
         h_eff = eff_dim(map_height_q);
         for (i = 0; i < ITEMS_PER_PHASE; i++) begin
            // mostly centers on the map, rows biased to the top and bottom edges
            if ($urandom_range(9) < 8) cx = $urandom_range(w_eff - 1);
            else                       cx = $urandom_range(255);
            k = $urandom_range(9);
            if (k < 3) begin
               cy = $urandom_range(3);
            end else if (k < 6) begin
               t  = h_eff - 1 - int'($urandom_range(3));
               cy = (t < 0) ? 0 : t;
            end else begin
               cy = $urandom_range(255);
            end
            queue_center(cx, cy, $urandom_range(3));
         end
         wait_drained();
      end

      if (expected_sectors.size() != 0) begin
         $error("%0d predicted sectors never arrived", expected_sectors.size());
         failures++;
      end

      $display("covered %0d centers (%0d with no sector on the map), %0d sector beats checked",
               centers_accepted, empty_centers, sectors_checked);
      $display("over %0d register writes: narrow, square, hex and saturated maps",
               reg_writes);
      if (failures == 0) begin
         $display("hex_neighborhood_scanner_top regression: pass");
      end else begin
         $display("hex_neighborhood_scanner_top regression: fail");
      end
      $finish;
   end

endmodule
